/* src/srg_pkg.sv */
package srg_pkg;

  // Field widths of the stream words
  localparam int COLOUR_W   = 32;
  localparam int TEX_IDX_W  = 8;
  localparam int DEPTH_W    = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int PW_REG_W   = 9;
  localparam int PH_REG_W   = 9;
  localparam int SW_REG_W   = 13;
  localparam int SH_REG_W   = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_WIDTH  = 2'd0,
    CFG_PATTERN_HEIGHT = 2'd1,
    CFG_SCREEN_WIDTH   = 2'd2,
    CFG_SCREEN_HEIGHT  = 2'd3
  } cfg_reg_e;

  // Register reset values
  localparam int PW_RESET = 128;
  localparam int PH_RESET = 128;
  localparam int SW_RESET = 640;
  localparam int SH_RESET = 480;

  // Row counter: rows per frame never exceed SCREEN_HEIGHT_LIMIT
  localparam int SCREEN_HEIGHT_LIMIT = 4096;
  localparam int ROW_W               = 13;

  // Parameter defaults
  localparam int DEFAULT_MAX_PATTERN_WIDTH  = 256;
  localparam int DEFAULT_MAX_PATTERN_HEIGHT = 256;
  localparam int DEFAULT_MAX_SCREEN_WIDTH   = 4096;

  // Opcodes of the input word
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    ST_PREP = 2'd0,
    ST_DIV  = 2'd1,
    ST_RUN  = 2'd2
  } ctl_state_e;

  typedef struct packed {
    logic                 op;
    logic [TEX_IDX_W-1:0] texel_col;
    logic [TEX_IDX_W-1:0] texel_row;
    logic [COLOUR_W-1:0]  texel_colour;
    logic [DEPTH_W-1:0]   depth;
  } in_word_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic                row_end;
    logic                frame_end;
  } out_word_t;

endpackage

/* src/srg_stream_if.sv */
interface srg_in_if;
  logic               valid;
  logic               ready;
  srg_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srg_out_if;
  logic               valid;
  logic               ready;
  srg_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/srg_rem.sv */
// Bit-serial restoring remainder, one dividend bit per cycle.
module srg_rem #(
  parameter int Width = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic [Width-1:0] rem_o,
  output logic             busy_o
);

  localparam int CntW = $clog2(Width + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] num_q, num_d;
  logic [Width-1:0] div_q, div_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;

  always_comb begin
    shifted = {rem_q, num_q[Width-1]};
    diff    = shifted - {1'b0, div_q};
    cnt_d   = cnt_q;
    num_d   = num_q;
    div_d   = div_q;
    rem_d   = rem_q;
    if (start_i) begin
      cnt_d = CntW'(Width);
      num_d = dividend_i;
      div_d = divisor_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      num_d = {num_q[Width-2:0], 1'b0};
      rem_d = (shifted >= {1'b0, div_q}) ? diff[Width-1:0] : shifted[Width-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rem_o  = rem_q;
  assign busy_o = (cnt_q != '0);

endmodule

/* src/stereogram_row_generator.sv */
// Random-dot stereogram generator. Load the dot pattern first with load words
// (op = 0, one texel each), then stream depth words (op = 1) row by row, each
// row from its rightmost column down to column 0; every depth word yields one
// colour word, with row_end on column 0 and frame_end on column 0 of the last
// row. Load words yield nothing. Throughput is one word per clock while out_o
// is ready and no positions are being recomputed: a depth word reads the pattern
// RAM or the recent-output ring as it is accepted, and its colour then passes
// from stage 1 into the output register. A one-word stage plus the output
// register let the input keep flowing while a finished word waits downstream.
// The pattern and ring RAMs hold garbage after reset; read only pattern texels
// that were loaded. After reset and after every configuration write, ready stays
// low while three bit-serial remainder units recompute the column and row
// positions modulo the pattern size; configure only while idle.
module stereogram_row_generator #(
  parameter int MAX_PATTERN_WIDTH  = srg_pkg::DEFAULT_MAX_PATTERN_WIDTH,
  parameter int MAX_PATTERN_HEIGHT = srg_pkg::DEFAULT_MAX_PATTERN_HEIGHT,
  parameter int MAX_SCREEN_WIDTH   = srg_pkg::DEFAULT_MAX_SCREEN_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  srg_in_if.sink                          in_i,
  srg_out_if.source                       out_o
);

  // Column quantities (x, widths, depth, x + width) share one width
  localparam int PwValW = $clog2(MAX_PATTERN_WIDTH + 1);
  localparam int SwValW = $clog2(MAX_SCREEN_WIDTH + 1);
  localparam int BaseW  = (PwValW > SwValW) ? PwValW : SwValW;
  localparam int CW     = ((BaseW > srg_pkg::DEPTH_W) ? BaseW : srg_pkg::DEPTH_W) + 1;
  localparam int RW     = srg_pkg::ROW_W;
  localparam int DW     = (CW > RW) ? CW : RW;
  // Pattern RAM is addressed {row, col}; the output ring by column bits
  localparam int PcW    = $clog2(MAX_PATTERN_WIDTH);
  localparam int PrW    = (MAX_PATTERN_HEIGHT > 1) ? $clog2(MAX_PATTERN_HEIGHT) : 1;
  localparam int PatDepth = 2 ** (PrW + PcW);
  localparam int RecDepth = 2 ** PcW;
  localparam int CmpW   = 16;

  function automatic logic [CmpW-1:0] clamp_val(input logic [CmpW-1:0] v,
                                                input logic [CmpW-1:0] hi);
    logic [CmpW-1:0] r;
    r = v;
    if (v == '0) r = CmpW'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  // Registers hold the clamped values directly.
  logic [CW-1:0] pw_q;
  logic [RW-1:0] ph_q;
  logic [CW-1:0] sw_q;
  logic [RW-1:0] sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= CW'(clamp_val(CmpW'(srg_pkg::PW_RESET), CmpW'(MAX_PATTERN_WIDTH)));
      ph_q <= RW'(clamp_val(CmpW'(srg_pkg::PH_RESET), CmpW'(MAX_PATTERN_HEIGHT)));
      sw_q <= CW'(clamp_val(CmpW'(srg_pkg::SW_RESET), CmpW'(MAX_SCREEN_WIDTH)));
      sh_q <= RW'(clamp_val(CmpW'(srg_pkg::SH_RESET),
                            CmpW'(srg_pkg::SCREEN_HEIGHT_LIMIT)));
    end else if (cfg_we_i) begin
      case (srg_pkg::cfg_reg_e'(cfg_index_i))
        srg_pkg::CFG_PATTERN_WIDTH:
          pw_q <= CW'(clamp_val(CmpW'(cfg_data_i[srg_pkg::PW_REG_W-1:0]),
                                CmpW'(MAX_PATTERN_WIDTH)));
        srg_pkg::CFG_PATTERN_HEIGHT:
          ph_q <= RW'(clamp_val(CmpW'(cfg_data_i[srg_pkg::PH_REG_W-1:0]),
                                CmpW'(MAX_PATTERN_HEIGHT)));
        srg_pkg::CFG_SCREEN_WIDTH:
          sw_q <= CW'(clamp_val(CmpW'(cfg_data_i[srg_pkg::SW_REG_W-1:0]),
                                CmpW'(MAX_SCREEN_WIDTH)));
        srg_pkg::CFG_SCREEN_HEIGHT:
          sh_q <= RW'(clamp_val(CmpW'(cfg_data_i[srg_pkg::SH_REG_W-1:0]),
                                CmpW'(srg_pkg::SCREEN_HEIGHT_LIMIT)));
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  srg_pkg::ctl_state_e state_q, state_d;

  // Raw counters as the last pixel left them; normalized to the current
  // screen size only when positions are recomputed.
  logic [CW-1:0] cc_q, cc_d;
  logic [RW-1:0] rc_q, rc_d;
  // Position of the next pixel and its residues
  logic [CW-1:0] x_q, x_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] colmod_q, colmod_d;
  logic [RW-1:0] rowmod_q, rowmod_d;
  logic [CW-1:0] x0mod_q, x0mod_d;   // (screen_width - 1) mod pattern_width

  logic          cc_wrap;
  logic [CW-1:0] cc_norm;
  logic [RW-1:0] r_wrap;
  logic [RW-1:0] row_norm;
  logic [CW-1:0] x_norm;

  logic          rem_start;
  logic [DW-1:0] rem_x, rem_x0, rem_row;
  logic          busy_x, busy_x0, busy_row;
  logic          rem_busy;

  assign cc_wrap  = (cc_q >= sw_q);
  assign cc_norm  = cc_wrap ? '0 : cc_q;
  assign r_wrap   = rc_q + RW'(cc_wrap);
  assign row_norm = (r_wrap >= sh_q) ? '0 : r_wrap;
  assign x_norm   = sw_q - CW'(1) - cc_norm;
  assign rem_busy = busy_x | busy_x0 | busy_row;

  srg_rem #(.Width(DW)) u_rem_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (DW'(x_norm)),
    .divisor_i  (DW'(pw_q)),
    .rem_o      (rem_x),
    .busy_o     (busy_x)
  );

  srg_rem #(.Width(DW)) u_rem_x0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (DW'(sw_q - CW'(1))),
    .divisor_i  (DW'(pw_q)),
    .rem_o      (rem_x0),
    .busy_o     (busy_x0)
  );

  srg_rem #(.Width(DW)) u_rem_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (DW'(row_norm)),
    .divisor_i  (DW'(ph_q)),
    .rem_o      (rem_row),
    .busy_o     (busy_row)
  );

  // ---------------------------------------------------------------- stage 0
  logic          acc, acc_pix, acc_load;
  logic          s1_v_q, s1_v_d;
  logic          o_v_q;
  logic          s1_go;

  logic [CW-1:0] depth_x, pw_m1, dsat;
  logic [CW-1:0] x_plus_pw;
  logic          from_pat;
  logic [CW-1:0] pcol;
  logic [CW-1:0] rsum;
  logic [PcW-1:0] ridx;
  logic          row_end, frame_end;
  logic [RW-1:0] row_inc;
  logic          row_wrap;
  logic [RW-1:0] rowmod_inc;

  logic [CmpW-1:0] ld_col, ld_row;
  logic            ld_ok;

  logic [PrW+PcW-1:0] pat_addr;

  assign in_i.ready = (state_q == srg_pkg::ST_RUN) && (!s1_v_q || !o_v_q || out_o.ready);
  assign acc        = in_i.valid && in_i.ready;
  assign acc_pix    = acc && (in_i.data.op == srg_pkg::OP_PIXEL);
  assign acc_load   = acc && (in_i.data.op == srg_pkg::OP_LOAD);

  assign depth_x   = CW'(in_i.data.depth);
  assign pw_m1     = pw_q - CW'(1);
  assign dsat      = (depth_x > pw_m1) ? pw_m1 : depth_x;
  assign x_plus_pw = x_q + pw_q;
  // Rightmost pattern_width columns sample the pattern directly
  assign from_pat  = (x_plus_pw >= sw_q);
  assign pcol      = (colmod_q >= dsat) ? (colmod_q - dsat) : (colmod_q + pw_q - dsat);
  assign rsum      = x_plus_pw - dsat;
  assign ridx      = rsum[PcW-1:0];

  assign row_end    = (x_q == '0);
  assign frame_end  = row_end && (row_q == sh_q - RW'(1));
  assign row_inc    = row_q + RW'(1);
  assign row_wrap   = (row_inc >= sh_q);
  assign rowmod_inc = rowmod_q + RW'(1);

  assign ld_col   = CmpW'(in_i.data.texel_col);
  assign ld_row   = CmpW'(in_i.data.texel_row);
  assign ld_ok    = (ld_col < CmpW'(MAX_PATTERN_WIDTH)) &&
                    (ld_row < CmpW'(MAX_PATTERN_HEIGHT));
  assign pat_addr = acc_load ? {ld_row[PrW-1:0], ld_col[PcW-1:0]}
                             : {rowmod_q[PrW-1:0], pcol[PcW-1:0]};

  // Control FSM and position update
  always_comb begin
    state_d   = state_q;
    rem_start = 1'b0;
    cc_d      = cc_q;
    rc_d      = rc_q;
    x_d       = x_q;
    row_d     = row_q;
    colmod_d  = colmod_q;
    rowmod_d  = rowmod_q;
    x0mod_d   = x0mod_q;
    case (state_q)
      srg_pkg::ST_PREP: begin
        rem_start = 1'b1;
        x_d       = x_norm;
        row_d     = row_norm;
        state_d   = srg_pkg::ST_DIV;
      end
      srg_pkg::ST_DIV: begin
        if (!rem_busy) begin
          colmod_d = rem_x[CW-1:0];
          x0mod_d  = rem_x0[CW-1:0];
          rowmod_d = rem_row[RW-1:0];
          state_d  = srg_pkg::ST_RUN;
        end
      end
      srg_pkg::ST_RUN: begin
        if (acc_pix) begin
          if (row_end) begin
            cc_d     = '0;
            x_d      = sw_q - CW'(1);
            colmod_d = x0mod_q;
            row_d    = row_wrap ? '0 : row_inc;
            rc_d     = row_wrap ? '0 : row_inc;
            rowmod_d = (row_wrap || (rowmod_inc == ph_q)) ? '0 : rowmod_inc;
          end else begin
            cc_d     = sw_q - x_q;
            rc_d     = row_q;
            x_d      = x_q - CW'(1);
            colmod_d = (colmod_q == '0) ? pw_m1 : (colmod_q - CW'(1));
          end
        end
      end
      default: state_d = srg_pkg::ST_PREP;
    endcase
    // any register write invalidates the residues
    if (cfg_we_i) begin
      state_d = srg_pkg::ST_PREP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srg_pkg::ST_PREP;
      cc_q    <= '0;
      rc_q    <= '0;
    end else begin
      state_q <= state_d;
      cc_q    <= cc_d;
      rc_q    <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    row_q    <= row_d;
    colmod_q <= colmod_d;
    rowmod_q <= rowmod_d;
    x0mod_q  <= x0mod_d;
  end

  // ---------------------------------------------------------------- memories
  logic [srg_pkg::COLOUR_W-1:0] pat_mem [PatDepth];
  logic [srg_pkg::COLOUR_W-1:0] rec_mem [RecDepth];
  logic [srg_pkg::COLOUR_W-1:0] pat_rdata_q;
  logic [srg_pkg::COLOUR_W-1:0] rec_rdata_q;

  logic [srg_pkg::COLOUR_W-1:0] s1_colour;
  logic [PcW-1:0]               s1_idx_q;
  logic                         s1_pat_q;
  logic                         s1_fwd_q;
  logic [srg_pkg::COLOUR_W-1:0] s1_fwd_data_q;
  logic                         s1_row_end_q;
  logic                         s1_frame_end_q;

  always_ff @(posedge clk_i) begin
    if (acc_load && ld_ok) begin
      pat_mem[pat_addr] <= in_i.data.texel_colour;
    end else if (acc_pix) begin
      pat_rdata_q <= pat_mem[pat_addr];
    end
  end

  // Ring of recent outputs; written when a word leaves stage 1
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      rec_mem[s1_idx_q] <= s1_colour;
    end
    if (acc_pix) begin
      rec_rdata_q <= rec_mem[ridx];
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign s1_go     = s1_v_q && (!o_v_q || out_o.ready);
  assign s1_colour = s1_pat_q ? pat_rdata_q : (s1_fwd_q ? s1_fwd_data_q : rec_rdata_q);

  always_comb begin
    s1_v_d = s1_v_q;
    if (acc_pix) begin
      s1_v_d = 1'b1;
    end else if (s1_go) begin
      s1_v_d = 1'b0;
    end
  end

  // The word in stage 1 writes the ring in the same cycle a new word reads
  // it; the neighbor column is bypassed from stage 1.
  always_ff @(posedge clk_i) begin
    if (acc_pix) begin
      s1_idx_q       <= x_q[PcW-1:0];
      s1_pat_q       <= from_pat;
      s1_fwd_q       <= s1_v_q && !from_pat && (s1_idx_q == ridx);
      s1_fwd_data_q  <= s1_colour;
      s1_row_end_q   <= row_end;
      s1_frame_end_q <= frame_end;
    end
  end

  // ---------------------------------------------------------------- output
  srg_pkg::out_word_t o_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      if (s1_go) begin
        o_v_q <= 1'b1;
      end else if (out_o.ready) begin
        o_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      o_data_q.colour    <= s1_colour;
      o_data_q.row_end   <= s1_row_end_q;
      o_data_q.frame_end <= s1_frame_end_q;
    end
  end

  assign out_o.valid = o_v_q;
  assign out_o.data  = o_data_q;

  // ---------------------------------------------------------------- checks
  a_colmod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srg_pkg::ST_RUN) |-> (colmod_q < pw_q) && (x0mod_q < pw_q))
    else $error("column residue out of range");

  a_rowmod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srg_pkg::ST_RUN) |-> (rowmod_q < ph_q) && (row_q < sh_q))
    else $error("row position out of range");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srg_pkg::ST_RUN) |-> (x_q < sw_q))
    else $error("column position out of range");

  a_frame_on_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.frame_end |-> out_o.data.row_end)
    else $error("frame_end without row_end");

  a_fwd_ring_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s1_fwd_q |-> !s1_pat_q)
    else $error("bypass taken on a pattern read");

endmodule
